// ===== rtl/cubic_bezier_easing_core_defines.svh =====
// Assertion macros shared by the cubic-Bezier easing core.
// Included by files that carry concurrent checks; depends on nothing.
`ifndef CUBIC_BEZIER_EASING_CORE_DEFINES_SVH
`define CUBIC_BEZIER_EASING_CORE_DEFINES_SVH

// Concurrent check on a named clock and active-low reset.
`define CBE_ASSERT_CLK(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Concurrent check on the core clock and reset.
`define CBE_ASSERT(label, prop, msg) \
  `CBE_ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`endif

// ===== rtl/cbe_pkg.sv =====
// Package of the cubic-Bezier easing core: constants, codes and the token type.
// Used by cbe_curve, cbe_cell and cubic_bezier_easing_core; depends on nothing.
`default_nettype none

package cbe_pkg;

  localparam int MAX_STEPS = 24;
  localparam int TOLERANCE = 66;

  localparam int M_BITS   = 24;
  localparam int M_W      = M_BITS + 1;
  localparam int COEF_W   = 22;
  localparam int PROD_W   = COEF_W + M_W + 1;
  localparam int SUM_W    = PROD_W + 1;
  localparam int VAL_W    = SUM_W - M_BITS;
  localparam int Q16_BITS = 16;

  localparam int PROG_W = 19;
  localparam int X_W    = 17;
  localparam int Y_W    = 20;
  localparam int EASED_W = 20;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 20;

  localparam logic [M_W-1:0] ONE_M = M_W'(1) << M_BITS;
  localparam logic [X_W-1:0] ONE_X = X_W'(1) << Q16_BITS;
  localparam logic signed [PROG_W-1:0] ONE_PROG = PROG_W'(1) << Q16_BITS;
  localparam logic signed [VAL_W-1:0] EASED_MAX = VAL_W'(262144);
  localparam logic signed [VAL_W-1:0] EASED_MIN = -VAL_W'(262144);
  localparam logic signed [EASED_W-1:0] EASED_ONE = EASED_W'(1) << Q16_BITS;

  localparam logic [X_W-1:0] X1_RESET = X_W'(16384);
  localparam logic [Y_W-1:0] Y1_RESET = Y_W'(16384);
  localparam logic [X_W-1:0] X2_RESET = X_W'(49152);
  localparam logic [Y_W-1:0] Y2_RESET = Y_W'(49152);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_X1 = 2'd0,
    CFG_Y1 = 2'd1,
    CFG_X2 = 2'd2,
    CFG_Y2 = 2'd3
  } cbe_cfg_e;

  typedef enum logic [1:0] {
    KIND_ZERO  = 2'd0,
    KIND_ONE   = 2'd1,
    KIND_PASS  = 2'd2,
    KIND_CURVE = 2'd3
  } cbe_kind_e;

  typedef struct packed {
    logic signed [PROG_W-1:0] progress;
    cbe_kind_e                kind;
    logic [M_W-1:0]           lo;
    logic [M_W-1:0]           hi;
    logic                     done;
    logic [M_W-1:0]           m_hit;
  } cbe_tok_t;

endpackage

`default_nettype wire

// ===== rtl/cbe_curve.sv =====
// Four-stage pipelined evaluation of a unit cubic Bezier coordinate at parameter m.
// Depends on cbe_pkg; carries a cbe_tok_t alongside the data.
`default_nettype none

module cbe_curve (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 en_i,
  input  logic                                 valid_i,
  input  logic [cbe_pkg::M_W-1:0]              m_i,
  input  logic signed [cbe_pkg::COEF_W-1:0]    coef_a_i,
  input  logic signed [cbe_pkg::COEF_W-1:0]    coef_b_i,
  input  cbe_pkg::cbe_tok_t                    tok_i,
  output logic                                 valid_o,
  output logic signed [cbe_pkg::VAL_W-1:0]     value_o,
  output cbe_pkg::cbe_tok_t                    tok_o
);
  import cbe_pkg::*;

  logic [M_W-1:0]   u;
  logic [2*M_W-1:0] uu_full, mm_full;
  logic             s1_valid_q;
  logic [M_W-1:0]   s1_m_q, s1_u_q, s1_u2_q, s1_m2_q;
  cbe_tok_t         s1_tok_q;

  logic [2*M_W-1:0] a_full, b_full, c_full;
  logic             s2_valid_q;
  logic [M_W-1:0]   s2_a_q, s2_b_q, s2_c_q;
  cbe_tok_t         s2_tok_q;

  logic signed [PROD_W-1:0] pa_d, qb_d;
  logic                     s3_valid_q;
  logic signed [PROD_W-1:0] s3_pa_q, s3_qb_q;
  logic [M_W-1:0]           s3_c_q;
  cbe_tok_t                 s3_tok_q;

  logic signed [SUM_W-1:0] c_term, rnd, v_sum;
  logic                    s4_valid_q;
  logic signed [VAL_W-1:0] s4_value_q;
  cbe_tok_t                s4_tok_q;

  assign u       = ONE_M - m_i;
  assign uu_full = u * u;
  assign mm_full = m_i * m_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
    end else if (en_i) begin
      s1_valid_q <= valid_i;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
      s4_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_m_q   <= m_i;
      s1_u_q   <= u;
      s1_u2_q  <= uu_full[M_BITS +: M_W];
      s1_m2_q  <= mm_full[M_BITS +: M_W];
      s1_tok_q <= tok_i;
    end
  end

  assign a_full = s1_u2_q * s1_m_q;
  assign b_full = s1_u_q * s1_m2_q;
  assign c_full = s1_m_q * s1_m2_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s2_a_q   <= a_full[M_BITS +: M_W];
      s2_b_q   <= b_full[M_BITS +: M_W];
      s2_c_q   <= c_full[M_BITS +: M_W];
      s2_tok_q <= s1_tok_q;
    end
  end

  assign pa_d = coef_a_i * $signed({1'b0, s2_a_q});
  assign qb_d = coef_b_i * $signed({1'b0, s2_b_q});

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s3_pa_q  <= pa_d;
      s3_qb_q  <= qb_d;
      s3_c_q   <= s2_c_q;
      s3_tok_q <= s2_tok_q;
    end
  end

  assign c_term = $signed({{(SUM_W-M_W-Q16_BITS){1'b0}}, s3_c_q, {Q16_BITS{1'b0}}});
  assign rnd    = $signed({{(SUM_W-M_BITS){1'b0}}, 1'b1, {(M_BITS-1){1'b0}}});
  assign v_sum  = SUM_W'(s3_pa_q) + SUM_W'(s3_qb_q) + c_term + rnd;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s4_value_q <= v_sum[SUM_W-1:M_BITS];
      s4_tok_q   <= s3_tok_q;
    end
  end

  assign valid_o = s4_valid_q;
  assign value_o = s4_value_q;
  assign tok_o   = s4_tok_q;

endmodule

`default_nettype wire

// ===== rtl/cbe_cell.sv =====
// One bisection cell: evaluates x at the interval midpoint and narrows the interval.
// Depends on cbe_pkg and cbe_curve.
`default_nettype none

module cbe_cell (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic signed [cbe_pkg::COEF_W-1:0] px3_i,
  input  logic signed [cbe_pkg::COEF_W-1:0] qx3_i,
  input  logic                              valid_i,
  input  cbe_pkg::cbe_tok_t                 tok_i,
  output logic                              valid_o,
  output cbe_pkg::cbe_tok_t                 tok_o
);
  import cbe_pkg::*;

  logic [M_W:0]            mid_sum, mid2_sum;
  logic [M_W-1:0]          mid, mid2;
  logic                    c_valid;
  logic signed [VAL_W-1:0] est;
  cbe_tok_t                c_tok;
  logic signed [VAL_W-1:0] t_ext;
  logic signed [VAL_W:0]   diff, abs_diff;
  logic                    hit;
  cbe_tok_t                tok_d;
  logic                    valid_q;
  cbe_tok_t                tok_q;

  assign mid_sum = {1'b0, tok_i.lo} + {1'b0, tok_i.hi};
  assign mid     = mid_sum[M_W:1];

  cbe_curve u_curve (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en_i),
    .valid_i  (valid_i),
    .m_i      (mid),
    .coef_a_i (px3_i),
    .coef_b_i (qx3_i),
    .tok_i    (tok_i),
    .valid_o  (c_valid),
    .value_o  (est),
    .tok_o    (c_tok)
  );

  assign mid2_sum = {1'b0, c_tok.lo} + {1'b0, c_tok.hi};
  assign mid2     = mid2_sum[M_W:1];
  assign t_ext    = VAL_W'(c_tok.progress);
  assign diff     = (VAL_W+1)'(t_ext) - (VAL_W+1)'(est);
  assign abs_diff = diff[VAL_W] ? -diff : diff;
  assign hit      = abs_diff < (VAL_W+1)'(TOLERANCE);

  always_comb begin
    tok_d = c_tok;
    if (c_tok.kind == KIND_CURVE && !c_tok.done) begin
      if (hit) begin
        tok_d.done  = 1'b1;
        tok_d.m_hit = mid2;
      end else if (est < t_ext) begin
        tok_d.lo = mid2;
      end else begin
        tok_d.hi = mid2;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= c_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tok_q <= tok_d;
    end
  end

  assign valid_o = valid_q;
  assign tok_o   = tok_q;

endmodule

`default_nettype wire

// ===== rtl/cubic_bezier_easing_core.sv =====
// Cubic-Bezier easing core: a row of bisection cells followed by a y evaluator.
// Registers along the path: one input stage, five per cell, four in the y evaluator
// and one output register. One word per cycle is taken, set by the fully pipelined
// cell row; a stalled output freezes the whole row.
// Reset clears all valid flags and loads the control points 0.25, 0.25, 0.75, 0.75.
// Depends on cbe_pkg, cbe_cell, cbe_curve and cubic_bezier_easing_core_defines.svh.
`default_nettype none
`include "cubic_bezier_easing_core_defines.svh"

module cubic_bezier_easing_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [cbe_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [cbe_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  input  logic [23:0]                         s_axis_tdata_i,  // progress[18:0], zero pad
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  output logic [23:0]                         m_axis_tdata_o   // eased[19:0], zero pad
);
  import cbe_pkg::*;

  logic [X_W-1:0]           ctrl_x1_q, ctrl_x2_q;
  logic signed [Y_W-1:0]    ctrl_y1_q, ctrl_y2_q;
  logic [X_W-1:0]           x1_clamp, x2_clamp;
  logic [COEF_W-1:0]        x1_ext, x2_ext;
  logic signed [COEF_W-1:0] y1_ext, y2_ext;
  logic signed [COEF_W-1:0] px3, qx3, py3, qy3;
  logic                     identity;

  logic                     adv;
  logic signed [PROG_W-1:0] t_in;
  cbe_tok_t                 tok_in;
  logic                     in_valid_q;
  cbe_tok_t                 in_tok_q;

  logic                     chain_valid [MAX_STEPS+1];
  cbe_tok_t                 chain_tok   [MAX_STEPS+1];

  cbe_tok_t                 last_tok;
  logic [M_W:0]             fin_sum;
  logic [M_W-1:0]           m_fin;
  logic                     y_valid;
  logic signed [VAL_W-1:0]  y_value;
  cbe_tok_t                 y_tok;
  logic signed [VAL_W-1:0]  y_sat;
  logic signed [EASED_W-1:0] eased_d;
  logic                     out_valid_q;
  logic signed [EASED_W-1:0] eased_q;

  // Configuration registers.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_x1_q <= X1_RESET;
      ctrl_y1_q <= Y1_RESET;
      ctrl_x2_q <= X2_RESET;
      ctrl_y2_q <= Y2_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_X1:  ctrl_x1_q <= cfg_data_i[X_W-1:0];
        CFG_Y1:  ctrl_y1_q <= cfg_data_i[Y_W-1:0];
        CFG_X2:  ctrl_x2_q <= cfg_data_i[X_W-1:0];
        CFG_Y2:  ctrl_y2_q <= cfg_data_i[Y_W-1:0];
        default: ;
      endcase
    end
  end

  assign x1_clamp = (ctrl_x1_q > ONE_X) ? ONE_X : ctrl_x1_q;
  assign x2_clamp = (ctrl_x2_q > ONE_X) ? ONE_X : ctrl_x2_q;
  assign x1_ext   = COEF_W'(x1_clamp);
  assign x2_ext   = COEF_W'(x2_clamp);
  assign px3      = $signed(x1_ext + (x1_ext << 1));
  assign qx3      = $signed(x2_ext + (x2_ext << 1));
  assign y1_ext   = COEF_W'(ctrl_y1_q);
  assign y2_ext   = COEF_W'(ctrl_y2_q);
  assign py3      = y1_ext + (y1_ext <<< 1);
  assign qy3      = y2_ext + (y2_ext <<< 1);
  assign identity = ($signed({{(Y_W-X_W){1'b0}}, ctrl_x1_q}) == ctrl_y1_q) &&
                    ($signed({{(Y_W-X_W){1'b0}}, ctrl_x2_q}) == ctrl_y2_q);

  // The whole row advances together while the output register can move.
  assign adv             = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = adv;

  assign t_in = $signed(s_axis_tdata_i[PROG_W-1:0]);

  always_comb begin
    tok_in.progress = t_in;
    tok_in.lo       = '0;
    tok_in.hi       = ONE_M;
    tok_in.done     = 1'b0;
    tok_in.m_hit    = '0;
    if (t_in <= 0) begin
      tok_in.kind = KIND_ZERO;
    end else if (t_in >= ONE_PROG) begin
      tok_in.kind = KIND_ONE;
    end else if (identity) begin
      tok_in.kind = KIND_PASS;
    end else begin
      tok_in.kind = KIND_CURVE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (adv) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      in_tok_q <= tok_in;
    end
  end

  assign chain_valid[0] = in_valid_q;
  assign chain_tok[0]   = in_tok_q;

  for (genvar g = 0; g < MAX_STEPS; g++) begin : g_cell
    cbe_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .px3_i   (px3),
      .qx3_i   (qx3),
      .valid_i (chain_valid[g]),
      .tok_i   (chain_tok[g]),
      .valid_o (chain_valid[g+1]),
      .tok_o   (chain_tok[g+1])
    );
  end

  assign last_tok = chain_tok[MAX_STEPS];
  assign fin_sum  = {1'b0, last_tok.lo} + {1'b0, last_tok.hi};
  assign m_fin    = last_tok.done ? last_tok.m_hit : fin_sum[M_W:1];

  cbe_curve u_y_curve (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (adv),
    .valid_i  (chain_valid[MAX_STEPS]),
    .m_i      (m_fin),
    .coef_a_i (py3),
    .coef_b_i (qy3),
    .tok_i    (last_tok),
    .valid_o  (y_valid),
    .value_o  (y_value),
    .tok_o    (y_tok)
  );

  always_comb begin
    if (y_value > EASED_MAX) begin
      y_sat = EASED_MAX;
    end else if (y_value < EASED_MIN) begin
      y_sat = EASED_MIN;
    end else begin
      y_sat = y_value;
    end
    case (y_tok.kind)
      KIND_ZERO:  eased_d = '0;
      KIND_ONE:   eased_d = EASED_ONE;
      KIND_PASS:  eased_d = EASED_W'(y_tok.progress);
      KIND_CURVE: eased_d = y_sat[EASED_W-1:0];
      default:    eased_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= y_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      eased_q <= eased_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(24-EASED_W){1'b0}}, eased_q};

  `CBE_ASSERT(a_eased_range, m_axis_tvalid_o |-> ((eased_q <= EASED_MAX[EASED_W-1:0]) || (eased_q >= EASED_MIN[EASED_W-1:0])), "eased word outside saturation range")
  `CBE_ASSERT(a_ready_follows_out, s_axis_tready_o == (!m_axis_tvalid_o || m_axis_tready_i), "input ready does not track output stall")
  `CBE_ASSERT(a_stall_freezes_row, (m_axis_tvalid_o && !m_axis_tready_i) |=> $stable(in_valid_q) && $stable(out_valid_q), "pipeline moved while output stalled")

endmodule

`default_nettype wire

// ===== tb/tb_cubic_bezier_easing_core.sv =====
// Self-checking testbench for the cubic-Bezier easing core: drives progress words and
// control-point writes, predicts each eased word and compares it with the output stream.
// Depends on cbe_pkg and cubic_bezier_easing_core.
`timescale 1ns / 100ps

module tb_cubic_bezier_easing_core;
  import cbe_pkg::*;

  localparam longint M_UNITY = 64'sd16777216;
  localparam longint Q16_UNITY = 64'sd65536;
  localparam longint EASED_TOP = 64'sd262144;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic s_axis_tvalid_i;
  logic s_axis_tready_o;
  logic [23:0] s_axis_tdata_i;  // progress[18:0], zero pad
  logic m_axis_tvalid_o;
  logic m_axis_tready_i;
  logic [23:0] m_axis_tdata_o;  // eased[19:0], zero pad

  logic [X_W-1:0] ctrl_x1, ctrl_x2;
  logic [Y_W-1:0] ctrl_y1, ctrl_y2;
  logic [23:0] eased_due[$];
  logic [23:0] want;
  int errors = 0;
  bit tx_idles, rx_idles;
  int rx_hold = 0;

  cubic_bezier_easing_core dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i(cfg_data_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i(s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o(m_axis_tdata_o)
  );

  always #4 clk_i = ~clk_i;

  // Bezier value in Q16 for inner controls p and q at parameter m (Q24).
  function automatic longint bezier_q16(longint p, longint q, longint m);
    longint u, u2, a, m2, b, c, v;
    u = M_UNITY - m;
    u2 = (u * u) >>> 24;
    a = (u2 * m) >>> 24;
    m2 = (m * m) >>> 24;
    b = (u * m2) >>> 24;
    c = (m * m2) >>> 24;
    v = 3 * p * a + 3 * q * b + c * Q16_UNITY;
    return (v + 64'sd8388608) >>> 24;
  endfunction

  function automatic logic [23:0] predict_eased(logic signed [PROG_W-1:0] t);
    longint tv, y1, y2, px, qx, r, lo, hi, mid, est, diff;
    bit done;
    tv = t;
    y1 = $signed(ctrl_y1);
    y2 = $signed(ctrl_y2);
    px = (ctrl_x1 > ONE_X) ? Q16_UNITY : longint'(ctrl_x1);
    qx = (ctrl_x2 > ONE_X) ? Q16_UNITY : longint'(ctrl_x2);
    lo = 0;
    hi = M_UNITY;
    done = 1'b0;
    r = 0;
    if (tv <= 0) begin
      r = 0;
    end else if (tv >= Q16_UNITY) begin
      r = Q16_UNITY;
    end else if (longint'(ctrl_x1) == y1 && longint'(ctrl_x2) == y2) begin
      r = tv;
    end else begin
      for (int i = 0; i < MAX_STEPS && !done; i++) begin
        mid = (lo + hi) >>> 1;
        est = bezier_q16(px, qx, mid);
        diff = (tv > est) ? tv - est : est - tv;
        if (diff < TOLERANCE) begin
          r = bezier_q16(y1, y2, mid);
          done = 1'b1;
        end else if (est < tv) begin
          lo = mid;
        end else begin
          hi = mid;
        end
      end
      if (!done) r = bezier_q16(y1, y2, (lo + hi) >>> 1);
    end
    if (r > EASED_TOP) r = EASED_TOP;
    if (r < -EASED_TOP) r = -EASED_TOP;
    return {4'b0, r[19:0]};
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (eased_due.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual %h", $time, m_axis_tdata_o);
        errors++;
      end else begin
        want = eased_due.pop_front();
        if (m_axis_tdata_o !== want) begin
          $display("%0t: eased mismatch, expected %h, actual %h", $time, want,
                   m_axis_tdata_o);
          errors++;
        end
      end
    end
  end

  // Output side: random stalls, and a long hold-off on request.
  initial begin
    m_axis_tready_i = 1'b0;
    @(posedge clk_i);
    forever begin
      if (rx_hold > 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (rx_hold) @(posedge clk_i);
        rx_hold = 0;
      end else if (rx_idles && $urandom_range(0, 2) == 0) begin
        m_axis_tready_i <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
      end else begin
        m_axis_tready_i <= 1'b1;
        repeat ($urandom_range(1, 40)) @(posedge clk_i);
      end
    end
  end

  task automatic send_progress(input logic signed [PROG_W-1:0] t);
    if (tx_idles && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    s_axis_tdata_i <= {5'b0, t};
    s_axis_tvalid_i <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready_o);
    eased_due.push_back(predict_eased(t));
  endtask

  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    do @(posedge clk_i); while (eased_due.size() != 0);
  endtask

  task automatic write_reg(input cbe_cfg_e idx, input logic [CFG_DATA_W-1:0] data);
    cfg_index_i <= idx;
    cfg_data_i <= data;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_X1: ctrl_x1 = data[X_W-1:0];
      CFG_Y1: ctrl_y1 = data;
      CFG_X2: ctrl_x2 = data[X_W-1:0];
      CFG_Y2: ctrl_y2 = data;
      default: ;
    endcase
  endtask

  task automatic set_curve(input logic [CFG_DATA_W-1:0] x1, input logic [CFG_DATA_W-1:0] y1,
                           input logic [CFG_DATA_W-1:0] x2, input logic [CFG_DATA_W-1:0] y2);
    drain();
    write_reg(CFG_X1, x1);
    write_reg(CFG_Y1, y1);
    write_reg(CFG_X2, x2);
    write_reg(CFG_Y2, y2);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_x();
    logic [CFG_DATA_W-1:0] x;
    case ($urandom_range(0, 7))
      0: x = 0;
      1: x = 65536;
      2: x = CFG_DATA_W'($urandom_range(65537, 131071));
      default: x = CFG_DATA_W'($urandom_range(0, 65536));
    endcase
    x[19:17] = 3'($urandom_range(0, 7));
    return x;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_y();
    case ($urandom_range(0, 7))
      0: return -20'sd262144;
      1: return 20'sd262144;
      2: return CFG_DATA_W'($urandom_range(0, 1048575));
      default: return CFG_DATA_W'($urandom_range(0, 524288) - 262144);
    endcase
  endfunction

  task automatic set_random_curve();
    logic [CFG_DATA_W-1:0] x1, y1, x2, y2;
    x1 = pick_x();
    x2 = pick_x();
    y1 = pick_y();
    y2 = pick_y();
    if ($urandom_range(0, 5) == 0) begin
      y1 = {3'b0, x1[16:0]};
      y2 = {3'b0, x2[16:0]};
    end
    set_curve(x1, y1, x2, y2);
  endtask

  function automatic logic signed [PROG_W-1:0] pick_progress();
    logic signed [PROG_W-1:0] t;
    case ($urandom_range(0, 9))
      0: t = PROG_W'($urandom_range(0, 524287));
      1: begin
        t = PROG_W'($urandom_range(0, 65536));
        t = -t;
      end
      2: t = PROG_W'(65536 + $urandom_range(0, 65536));
      default: t = PROG_W'($urandom_range(1, 65535));
    endcase
    return t;
  endfunction

  task automatic test_reset_curve();
    send_progress(-19'sd262144);
    send_progress(-19'sd1);
    send_progress(19'sd0);
    send_progress(19'sd1);
    send_progress(19'sd32768);
    send_progress(19'sd65535);
    send_progress(19'sd65536);
    send_progress(19'sd65537);
    send_progress(19'sd262143);
  endtask

  task automatic test_identity();
    set_curve(20000, 20000, 40000, 40000);
    send_progress(19'sd1);
    send_progress(19'sd12345);
    send_progress(19'sd65535);
    // Identity holds on the raw registers even where x is out of range.
    set_curve(100000, 100000, 0, 0);
    send_progress(19'sd5000);
    send_progress(19'sd50000);
  endtask

  task automatic test_clamp_and_overshoot();
    set_curve(20'hFFFFF, 20'h7FFFF, 0, 20'h80000);
    send_progress(19'sd1000);
    send_progress(19'sd32768);
    send_progress(19'sd64000);
    set_curve(65536, -20'sd262144, 0, 20'sd262144);
    send_progress(19'sd3);
    send_progress(19'sd32768);
    send_progress(19'sd65000);
  endtask

  task automatic test_random_curves();
    for (int ph = 0; ph < 20; ph++) begin
      if (ph == 0) set_curve(0, -20'sd262144, 0, -20'sd262144);
      else if (ph == 1) set_curve(65536, 20'sd262144, 65536, 20'sd262144);
      else set_random_curve();
      rx_idles = (ph % 4 != 3);
      tx_idles = rx_idles;
      for (int k = 0; k < 90; k++) send_progress(pick_progress());
    end
  endtask

  task automatic test_backpressure();
    set_random_curve();
    tx_idles = 1'b0;
    rx_idles = 1'b1;
    rx_hold = 400;
    for (int k = 0; k < 300; k++) send_progress(pick_progress());
    // The sender now waits for every outstanding word before going on.
    drain();
  endtask

  task automatic test_full_rate();
    set_random_curve();
    tx_idles = 1'b0;
    rx_idles = 1'b0;
    for (int k = 0; k < 150; k++) send_progress(pick_progress());
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_X1;
    cfg_data_i = '0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i = '0;
    tx_idles = 1'b1;
    rx_idles = 1'b1;
    ctrl_x1 = X1_RESET;
    ctrl_y1 = Y1_RESET;
    ctrl_x2 = X2_RESET;
    ctrl_y2 = Y2_RESET;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_reset_curve();
    test_identity();
    test_clamp_and_overshoot();
    test_random_curves();
    test_backpressure();
    test_full_rate();
    drain();
    repeat (140) @(posedge clk_i);
    if (errors == 0) $display("tb_cubic_bezier_easing_core OK");
    else $display("tb_cubic_bezier_easing_core NOT OK");
    $finish;
  end

  initial begin
    #5000000;
    $display("tb_cubic_bezier_easing_core NOT OK");
    $finish;
  end

endmodule
